@@ rtl/page_framebuffer_with_refresh_unit_defines.svh @@
// assertion macros for the page framebuffer with refresh unit
`ifndef PAGE_FRAMEBUFFER_WITH_REFRESH_UNIT_DEFINES_SVH
`define PAGE_FRAMEBUFFER_WITH_REFRESH_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, quiet during rst
`define PFB_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("pfb same-cycle check failed");

// next-cycle implication, checked on clk, quiet during rst
`define PFB_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("pfb next-cycle check failed");

`endif

@@ rtl/pfb_pkg.sv @@
// shared constants, payload types and control structs of the page framebuffer
package pfb_pkg;

  localparam int WIDTH        = 128;
  localparam int HEIGHT       = 64;
  localparam int PAGES        = (HEIGHT + 7) / 8;
  localparam int STORE_BYTES  = WIDTH * PAGES;
  localparam int HEADER_BYTES = 3;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int COL_W  = $clog2(WIDTH);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int POS_W  = $clog2(WIDTH + HEADER_BYTES);

  // item opcodes
  localparam logic [1:0] OP_PIXEL   = 2'd0;
  localparam logic [1:0] OP_FILL    = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  // register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_CMD_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_LOW_CMD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_HIGH_CMD  = 2'd2;

  localparam logic [7:0] RST_PAGE_CMD_BASE = 8'h80;
  localparam logic [7:0] RST_COL_LOW_CMD   = 8'h02;
  localparam logic [7:0] RST_COL_HIGH_CMD  = 8'h10;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] x;
    logic [7:0] y;
    logic       color;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       frame_last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic pix_read;
    logic pix_write;
    logic fill_start;
    logic fill_step;
    logic refresh_start;
    logic emit_header;
    logic data_read;
    logic emit_data;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       pix_in_range;
    logic       fill_busy;
    logic       fill_last;
    logic       refresh_busy;
    logic       header;
    logic       out_busy;
  } status_t;

endpackage

@@ rtl/pfb_ram.sv @@
// generic single-write, single-read memory with registered read data
module pfb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/pfb_datapath.sv @@
// framebuffer datapath: item register, store, fill and refresh counters, output register
module pfb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  pfb_pkg::req_t                 req,
  input  logic                          cfg_valid,
  input  logic [pfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output pfb_pkg::rsp_t                 rsp,
  input  pfb_pkg::cmd_t                 cmd,
  output pfb_pkg::status_t              st
);

  localparam logic [pfb_pkg::POS_W-1:0] POS_PAGE    = pfb_pkg::POS_W'(0);
  localparam logic [pfb_pkg::POS_W-1:0] POS_COL_LOW = pfb_pkg::POS_W'(1);

  pfb_pkg::req_t item;

  logic [7:0] page_cmd_base;
  logic [7:0] col_low_cmd;
  logic [7:0] col_high_cmd;

  logic                        refresh_busy;
  logic [pfb_pkg::PAGE_W-1:0]  page_count;
  logic [pfb_pkg::POS_W-1:0]   byte_position;
  logic                        fill_busy;
  logic [pfb_pkg::ADDR_W-1:0]  fill_index;
  logic                        fill_value;

  logic                        pix_in_range;
  logic [pfb_pkg::PAGE_W-1:0]  pix_page;
  logic [pfb_pkg::ADDR_W-1:0]  pix_addr;
  logic [7:0]                  pix_mask;
  logic [7:0]                  pix_byte;
  logic [pfb_pkg::COL_W-1:0]   col;
  logic [pfb_pkg::ADDR_W-1:0]  data_addr;
  logic                        end_page;
  logic                        last_byte;
  logic                        fill_last;
  logic [7:0]                  header_byte;

  logic                        ram_wr_en;
  logic [pfb_pkg::ADDR_W-1:0]  ram_wr_addr;
  logic [7:0]                  ram_wr_data;
  logic                        ram_rd_en;
  logic [pfb_pkg::ADDR_W-1:0]  ram_rd_addr;
  logic [7:0]                  ram_rd_data;

  // pixel address and bit mask
  assign pix_in_range = ({1'b0, item.x} < 9'(pfb_pkg::WIDTH)) &&
                        ({1'b0, item.y} < 9'(pfb_pkg::HEIGHT));
  assign pix_page = pfb_pkg::PAGE_W'(pfb_pkg::PAGES - 1) - pfb_pkg::PAGE_W'(item.y >> 3);
  assign pix_addr = pfb_pkg::ADDR_W'(pfb_pkg::ADDR_W'(item.x) *
                                     pfb_pkg::ADDR_W'(pfb_pkg::PAGES)) +
                    pfb_pkg::ADDR_W'(pix_page);
  assign pix_mask = 8'h80 >> item.y[2:0];
  assign pix_byte = item.color ? (ram_rd_data | pix_mask) : (ram_rd_data & ~pix_mask);

  // refresh position decode
  assign col       = pfb_pkg::COL_W'(byte_position - pfb_pkg::POS_W'(pfb_pkg::HEADER_BYTES));
  assign data_addr = pfb_pkg::ADDR_W'(pfb_pkg::ADDR_W'(col) *
                                      pfb_pkg::ADDR_W'(pfb_pkg::PAGES)) +
                     pfb_pkg::ADDR_W'(page_count);
  assign end_page  = (col == pfb_pkg::COL_W'(pfb_pkg::WIDTH - 1));
  assign last_byte = end_page && (page_count == pfb_pkg::PAGE_W'(pfb_pkg::PAGES - 1));
  assign fill_last = (fill_index == pfb_pkg::ADDR_W'(pfb_pkg::STORE_BYTES - 1));

  always_comb begin
    if (byte_position == POS_PAGE) begin
      header_byte = 8'(page_cmd_base + 8'(page_count));
    end else if (byte_position == POS_COL_LOW) begin
      header_byte = col_low_cmd;
    end else begin
      header_byte = col_high_cmd;
    end
  end

  // store ports
  assign ram_wr_en   = cmd.pix_write | cmd.fill_step;
  assign ram_wr_addr = cmd.pix_write ? pix_addr : fill_index;
  assign ram_wr_data = cmd.pix_write ? pix_byte : {8{fill_value}};
  assign ram_rd_en   = cmd.pix_read | cmd.data_read;
  assign ram_rd_addr = cmd.pix_read ? pix_addr : data_addr;

  pfb_ram #(
    .DATA_W (8),
    .DEPTH  (pfb_pkg::STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= req;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_cmd_base <= pfb_pkg::RST_PAGE_CMD_BASE;
      col_low_cmd   <= pfb_pkg::RST_COL_LOW_CMD;
      col_high_cmd  <= pfb_pkg::RST_COL_HIGH_CMD;
    end else if (cfg_valid) begin
      case (cfg_index)
        pfb_pkg::CFG_PAGE_CMD_BASE: page_cmd_base <= cfg_data;
        pfb_pkg::CFG_COL_LOW_CMD:   col_low_cmd   <= cfg_data;
        pfb_pkg::CFG_COL_HIGH_CMD:  col_high_cmd  <= cfg_data;
        default: ;
      endcase
    end
  end

  // fill sweep, also used for the clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_busy  <= 1'b0;
      fill_index <= '0;
      fill_value <= 1'b0;
    end else if (cmd.fill_start) begin
      fill_busy  <= 1'b1;
      fill_index <= '0;
      fill_value <= item.color;
    end else if (cmd.fill_step) begin
      if (fill_last) begin
        fill_busy  <= 1'b0;
        fill_index <= '0;
      end else begin
        fill_index <= fill_index + 1'b1;
      end
    end
  end

  // refresh walk
  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_busy  <= 1'b0;
      page_count    <= '0;
      byte_position <= '0;
    end else if (cmd.refresh_start) begin
      refresh_busy  <= 1'b1;
      page_count    <= '0;
      byte_position <= '0;
    end else if (cmd.emit_header) begin
      byte_position <= byte_position + 1'b1;
    end else if (cmd.emit_data) begin
      if (last_byte) begin
        refresh_busy  <= 1'b0;
        page_count    <= '0;
        byte_position <= '0;
      end else if (end_page) begin
        page_count    <= page_count + 1'b1;
        byte_position <= '0;
      end else begin
        byte_position <= byte_position + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit_header || cmd.emit_data) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_header) begin
      rsp <= '{out_byte: header_byte, is_command: 1'b1, frame_last: 1'b0};
    end else if (cmd.emit_data) begin
      rsp <= '{out_byte: ram_rd_data, is_command: 1'b0, frame_last: last_byte};
    end
  end

  assign st = '{
    op:           item.op,
    pix_in_range: pix_in_range,
    fill_busy:    fill_busy,
    fill_last:    fill_last,
    refresh_busy: refresh_busy,
    header:       (byte_position < pfb_pkg::POS_W'(pfb_pkg::HEADER_BYTES)),
    out_busy:     rsp_valid && rsp_stall
  };

endmodule

@@ rtl/pfb_ctrl.sv @@
// framebuffer controller state machine
module pfb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  pfb_pkg::status_t st,
  output pfb_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_PIX_WR = 3'd3;
  localparam logic [2:0] S_DATA   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.fill_step = 1'b1;
        if (st.fill_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (st.op)
          pfb_pkg::OP_PIXEL: begin
            if (st.pix_in_range) begin
              cmd.pix_read = 1'b1;
              state_next   = S_PIX_WR;
            end
          end
          pfb_pkg::OP_FILL: begin
            cmd.fill_start = 1'b1;
          end
          pfb_pkg::OP_REFRESH: begin
            cmd.refresh_start = !st.refresh_busy;
          end
          pfb_pkg::OP_TICK: begin
            if (st.fill_busy) begin
              cmd.fill_step = 1'b1;
            end else if (st.refresh_busy) begin
              if (!st.header) begin
                cmd.data_read = 1'b1;
                state_next    = S_DATA;
              end else if (st.out_busy) begin
                state_next = S_EXEC;
              end else begin
                cmd.emit_header = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      S_PIX_WR: begin
        cmd.pix_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_DATA: begin
        if (!st.out_busy) begin
          cmd.emit_data = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/page_framebuffer_with_refresh_unit.sv @@
// top level of the one-bit-per-pixel page framebuffer with serial refresh dump
//
//   channel   signals                          direction  payload
//   req       req_valid, req_stall, req        in         op, x, y, color
//   rsp       rsp_valid, rsp_stall, rsp        out        out_byte, is_command, frame_last
//   cfg       cfg_valid, cfg_ready, cfg_index  in         cfg_data (8 bits)
//
// steps: one item at a time; fill, refresh start, idle tick, command-byte tick and
//   out-of-range pixel finish in the decode state, in-range pixel write and data-byte tick
//   go on to a write-back or emit state (read then write/emit on the store port)
// a tick that emits waits further while the output register still holds an unread item
// reset: sync, active high; a clearing pass then zeroes all STORE_BYTES (1024) store bytes,
//   with req_stall high; configuration writes are taken throughout
// rsp has its own output register, so the next item is accepted while a byte waits
`include "page_framebuffer_with_refresh_unit_defines.svh"

module page_framebuffer_with_refresh_unit (
  input  logic                          clk,
  input  logic                          rst,
  // item input
  input  logic                          req_valid,
  output logic                          req_stall,
  input  pfb_pkg::req_t                 req,
  // panel byte output
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output pfb_pkg::rsp_t                 rsp,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  pfb_pkg::cmd_t    cmd;
  pfb_pkg::status_t st;

  // register writes never stall
  assign cfg_ready = 1'b1;

  // sequencing: decode, read-modify-write and emit steps
  pfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // store, counters, registers and output register
  pfb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (cmd),
    .st        (st)
  );

  // the single store write port is never claimed twice
  `PFB_ASSERT_NOW(a_one_writer, cmd.pix_write, !cmd.fill_step)
  // a waiting output byte is never overwritten
  `PFB_ASSERT_NOW(a_no_overwrite, cmd.emit_header || cmd.emit_data, !st.out_busy)
  // a pixel read is always followed by its write back
  `PFB_ASSERT_NEXT(a_pixel_rmw, cmd.pix_read, cmd.pix_write)
  // one item in flight: after an accept the input stalls
  `PFB_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall)

endmodule

@@ tb/tb_page_framebuffer_with_refresh_unit.sv @@
// self-checking testbench for the page framebuffer with serial refresh dump
`timescale 1ns / 1ps

module tb_page_framebuffer_with_refresh_unit;
  import pfb_pkg::*;

  // index past the register list, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 12;
  // ticks that walk one whole page of the dump
  localparam int PAGE_TICKS     = WIDTH + HEADER_BYTES;
  // reset clearing pass and the long receiver hold fit well inside
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int PRINT_CAP      = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       req_valid = 1'b0;
  logic       req_stall;
  req_t       req       = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_t       rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  page_framebuffer_with_refresh_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // items waiting to be offered, and panel bytes the block still owes us
  req_t pending_items[$];
  rsp_t expected_panel_bytes[$];

  // shadow of the block: store, dump walker, fill walker, command registers
  logic [7:0]        fb_bytes [0:STORE_BYTES-1];
  logic              dump_active = 1'b0;
  logic [PAGE_W-1:0] dump_page   = '0;
  logic [POS_W-1:0]  dump_pos    = '0;
  logic              fill_active = 1'b0;
  logic [ADDR_W-1:0] fill_pos    = '0;
  logic              fill_ones   = 1'b0;
  logic [7:0]        cmd_page_base = RST_PAGE_CMD_BASE;
  logic [7:0]        cmd_col_low   = RST_COL_LOW_CMD;
  logic [7:0]        cmd_col_high  = RST_COL_HIGH_CMD;

  int   mismatches   = 0;
  int   bytes_seen   = 0;
  int   quiet_cycles = 0;
  rsp_t want_byte;

  // idling knobs, owned by the stimulus process
  logic idling_on    = 1'b1;
  logic hold_request = 1'b0;

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) fb_bytes[i] = 8'h00;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // advance the shadow by one accepted item, queue the panel byte it emits
  task automatic predict_panel_byte(input req_t it);
    int   page_i;
    int   idx;
    int   col;
    logic [7:0] mask;
    rsp_t b;
    case (it.op)
      OP_PIXEL: begin
        // out-of-range pixels are dropped
        if (it.x < WIDTH && it.y < HEIGHT) begin
          page_i = PAGES - 1 - int'(it.y) / 8;
          idx    = int'(it.x) * PAGES + page_i;
          mask   = 8'h80 >> (it.y % 8);
          if (it.color) fb_bytes[idx] = fb_bytes[idx] | mask;
          else fb_bytes[idx] = fb_bytes[idx] & ~mask;
        end
      end
      OP_FILL: begin
        // a new fill restarts from byte zero
        fill_active = 1'b1;
        fill_pos    = '0;
        fill_ones   = it.color;
      end
      OP_REFRESH: begin
        // ignored while a dump runs
        if (!dump_active) begin
          dump_active = 1'b1;
          dump_page   = '0;
          dump_pos    = '0;
        end
      end
      OP_TICK: begin
        if (fill_active) begin
          // fill has priority, a pending dump waits
          fb_bytes[fill_pos] = fill_ones ? 8'hFF : 8'h00;
          if (int'(fill_pos) == STORE_BYTES - 1) begin
            fill_active = 1'b0;
            fill_pos    = '0;
          end else begin
            fill_pos = fill_pos + 1'b1;
          end
        end else if (dump_active) begin
          b.frame_last = 1'b0;
          b.is_command = 1'b1;
          if (dump_pos == 0) begin
            b.out_byte = cmd_page_base + dump_page;
            dump_pos   = dump_pos + 1'b1;
          end else if (dump_pos == 1) begin
            b.out_byte = cmd_col_low;
            dump_pos   = dump_pos + 1'b1;
          end else if (dump_pos == 2) begin
            b.out_byte = cmd_col_high;
            dump_pos   = dump_pos + 1'b1;
          end else begin
            col          = int'(dump_pos) - HEADER_BYTES;
            b.out_byte   = fb_bytes[col * PAGES + int'(dump_page)];
            b.is_command = 1'b0;
            if (col + 1 >= WIDTH) begin
              dump_pos = '0;
              if (int'(dump_page) + 1 >= PAGES) begin
                b.frame_last = 1'b1;
                dump_active  = 1'b0;
                dump_page    = '0;
              end else begin
                dump_page = dump_page + 1'b1;
              end
            end else begin
              dump_pos = dump_pos + 1'b1;
            end
          end
          expected_panel_bytes.push_back(b);
        end
      end
      default: ;
    endcase
  endtask

  // sender: offers queued items, random gaps after an item when idling is on
  int req_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else if (!req_valid || !req_stall) begin
      if (req_gap > 0) begin
        req_gap   <= req_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        req_valid <= 1'b1;
        req       <= pending_items.pop_front();
        if (idling_on && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 11);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  int   stall_left = 0;
  int   hold_left  = 0;
  logic hold_taken = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (hold_request && !hold_taken) begin
      // block fills its output register, then stalls its input
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      rsp_stall  <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall  <= 1'b1;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 10);
      rsp_stall  <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // monitor: check bytes first (they are older than any item taken this edge)
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        bytes_seen++;
        if (expected_panel_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %0d: %02h arrived with nothing expected",
                                    bytes_seen, rsp.out_byte));
        end else begin
          want_byte = expected_panel_bytes.pop_front();
          if (rsp.out_byte !== want_byte.out_byte)
            report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
                                      bytes_seen, rsp.out_byte, want_byte.out_byte));
          if (rsp.is_command !== want_byte.is_command)
            report_mismatch($sformatf("byte %0d: is_command %b, want %b",
                                      bytes_seen, rsp.is_command, want_byte.is_command));
          if (rsp.frame_last !== want_byte.frame_last)
            report_mismatch($sformatf("byte %0d: frame_last %b, want %b",
                                      bytes_seen, rsp.frame_last, want_byte.frame_last));
        end
      end
      if (req_valid && !req_stall) predict_panel_byte(req);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PAGE_CMD_BASE: cmd_page_base = cfg_data;
          CFG_COL_LOW_CMD:   cmd_col_low   = cfg_data;
          CFG_COL_HIGH_CMD:  cmd_col_high  = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push_item(input logic [1:0] op, input logic [7:0] x,
                                    input logic [7:0] y, input logic color);
    req_t it;
    it.op    = op;
    it.x     = x;
    it.y     = y;
    it.color = color;
    pending_items.push_back(it);
  endfunction

  // ticks carry don't-care coordinates, randomized so every bit toggles
  function automatic void push_ticks(input int n);
    for (int i = 0; i < n; i++) push_item(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
  endfunction

  // every queued item handed over and seen by the monitor
  task automatic wait_all_taken();
    do @(posedge clk); while (pending_items.size() != 0 || req_valid);
  endtask

  // every item taken, all bytes in, then a settling wait for items that emit nothing
  task automatic settle();
    wait_all_taken();
    while (expected_panel_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write, valid stays up for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input logic [7:0] base, input logic [7:0] lo,
                               input logic [7:0] hi);
    write_reg(CFG_PAGE_CMD_BASE, base);
    write_reg(CFG_COL_LOW_CMD, lo);
    write_reg(CFG_COL_HIGH_CMD, hi);
    write_reg(CFG_UNUSED_IDX, 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // mostly pixel writes and refresh-plus-tick runs, some stray coordinates
  task automatic random_phase(input int n_items);
    int   pushed;
    int   r;
    int   burst;
    logic [7:0] px;
    logic [7:0] py;
    pushed = 0;
    while (pushed < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 42) begin
        px = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, WIDTH - 1));
        py = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, HEIGHT - 1));
        push_item(OP_PIXEL, px, py, 1'($urandom));
        pushed++;
      end else if (r < 50) begin
        push_item(OP_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom));
        pushed++;
      end else begin
        burst = $urandom_range(1, 24);
        push_ticks(burst);
        pushed += burst;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset command values, corner pixels, out-of-range pixels, idle tick
    push_ticks(1);
    push_item(OP_PIXEL, 8'd0, 8'd0, 1'b1);
    push_item(OP_PIXEL, 8'(WIDTH - 1), 8'(HEIGHT - 1), 1'b1);
    push_item(OP_PIXEL, 8'(WIDTH - 1), 8'd0, 1'b1);
    push_item(OP_PIXEL, 8'd0, 8'(HEIGHT - 1), 1'b1);
    push_item(OP_PIXEL, 8'd37, 8'd21, 1'b1);
    push_item(OP_PIXEL, 8'd37, 8'd21, 1'b0);
    push_item(OP_PIXEL, 8'd38, 8'd21, 1'b1);
    push_item(OP_PIXEL, 8'(WIDTH), 8'd3, 1'b1);
    push_item(OP_PIXEL, 8'hFF, 8'hFF, 1'b1);
    push_item(OP_PIXEL, 8'd4, 8'(HEIGHT), 1'b1);
    // dump start, a second start while busy, a pixel landing mid-dump, on into page one
    push_item(OP_REFRESH, 8'd0, 8'd0, 1'b0);
    push_ticks(4);
    push_item(OP_REFRESH, 8'hFF, 8'hFF, 1'b1);
    push_item(OP_PIXEL, 8'd1, 8'(HEIGHT - 1), 1'b1);
    push_ticks(PAGE_TICKS + 10);
    settle();

    // extremes, page command wraps past 255 on the next page; long receiver hold here
    apply_setting(8'hFF, 8'h00, 8'hFF);
    push_ticks(PAGE_TICKS);
    hold_request <= 1'b1;
    random_phase(150);
    settle();

    apply_setting(8'h00, 8'hFF, 8'h00);
    random_phase(100);
    settle();

    // first half with no idling at all
    apply_setting(8'($urandom), 8'($urandom), 8'($urandom));
    idling_on <= 1'b0;
    random_phase(50);
    wait_all_taken();
    idling_on <= 1'b1;
    random_phase(50);
    settle();

    // closing stretch, no idling on either side; a fill holds the dump back,
    // then restarts with the other color
    apply_setting(8'($urandom), 8'($urandom), 8'($urandom));
    idling_on <= 1'b0;
    random_phase(90);
    push_item(OP_FILL, 8'd0, 8'd0, 1'b1);
    push_ticks(3);
    push_item(OP_REFRESH, 8'd0, 8'd0, 1'b0);
    push_item(OP_FILL, 8'hFF, 8'hFF, 1'b0);
    push_ticks(8);
    push_item(OP_PIXEL, 8'd2, 8'd2, 1'b1);
    push_ticks(8);
    settle();

    if (expected_panel_bytes.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", expected_panel_bytes.size()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
